// ===== rtl/core/mve_pkg.sv =====
// Shared constants and types for the MSB-first varint encoder.
package mve_pkg;

    localparam int GROUP_BITS = 7;

    typedef logic [GROUP_BITS-1:0] group_t;

    typedef struct packed {
        logic busy;
        logic emit;
        logic last;
    } ser_stat_t;

endpackage

// ===== rtl/core/mve_serializer.sv =====
// Group shift register that steps a value out one 7-bit group per cycle while advance is high, top group first.
module mve_serializer #(
    parameter int SR_BITS = 70
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [SR_BITS-1:0]   load_data,
    input  logic                 advance,
    output mve_pkg::group_t      group,
    output mve_pkg::ser_stat_t   stat
);

    localparam int NGROUPS = SR_BITS / mve_pkg::GROUP_BITS;
    localparam int CNT_W   = $clog2(NGROUPS + 1);

    logic [SR_BITS-1:0] sr_reg;
    logic [SR_BITS-1:0] sr_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               started_reg;
    logic               started_next;
    logic               nonzero;

    assign group   = sr_reg[SR_BITS-1 -: mve_pkg::GROUP_BITS];
    assign nonzero = |group;

    assign stat.busy = (cnt_reg != '0);
    assign stat.last = (cnt_reg == CNT_W'(1));
    assign stat.emit = started_reg | nonzero | stat.last;

    always_comb
    begin
        sr_next      = sr_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        if (load)
        begin
            sr_next      = load_data;
            cnt_next     = CNT_W'(NGROUPS);
            started_next = 1'b0;
        end
        else if (advance)
        begin
            sr_next      = {sr_reg[SR_BITS-mve_pkg::GROUP_BITS-1:0],
                            {mve_pkg::GROUP_BITS{1'b0}}};
            cnt_next     = cnt_reg - CNT_W'(1);
            started_next = started_reg | nonzero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg <= sr_next;
    end

endmodule

// ===== rtl/core/msb_first_varint_encoder.sv =====
// Top level: MSB-first varint encoder with optional zigzag mapping.
// Each transaction is one load, then one group per cycle when the output is not stalled;
// leading zero groups give no output. Later bytes follow one per cycle when not stalled.
// A new value is accepted once the last group has moved to the output register.
// Reset clears the shifter count and output valid; payload registers are not reset.
module msb_first_varint_encoder #(
    parameter int VALUE_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] value,
    input  logic        mode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last
);

    localparam int NGROUPS = (VALUE_BITS + mve_pkg::GROUP_BITS - 1) / mve_pkg::GROUP_BITS;
    localparam int SR_BITS = NGROUPS * mve_pkg::GROUP_BITS;

    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] zz;
    logic [VALUE_BITS-1:0] u;
    logic                  load;
    logic                  advance;
    mve_pkg::group_t       group;
    mve_pkg::ser_stat_t    stat;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       last_reg;

    assign v  = value[VALUE_BITS-1:0];
    assign zz = {v[VALUE_BITS-2:0], 1'b0} ^ {VALUE_BITS{v[VALUE_BITS-1]}};
    assign u  = mode ? zz : v;

    assign in_ready = !stat.busy;
    assign load     = in_valid && in_ready;
    assign advance  = stat.busy && (!out_valid_reg || out_ready);

    mve_serializer #(
        .SR_BITS (SR_BITS)
    ) u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_data (SR_BITS'(u)),
        .advance   (advance),
        .group     (group),
        .stat      (stat)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && stat.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stat.emit)
        begin
            out_byte_reg <= {~stat.last, group};
            last_reg     <= stat.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

`ifndef NO_ASSERTIONS
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> stat.busy)
        else $error("shifter not busy after accepted transaction");

    a_mark_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_byte[7] != last))
        else $error("continuation mark disagrees with last flag");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stat.last) |=> !stat.busy)
        else $error("shifter still busy after final group");

    a_final_out: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(stat.busy) |-> (out_valid && last))
        else $error("final group not presented at output");
`endif

endmodule
